// ===== rtl/core/diff_drive_odometry_integrator_macros.svh =====
// Assertion macros shared by the odometry integrator checker.
`ifndef DIFF_DRIVE_ODOMETRY_INTEGRATOR_MACROS_SVH
`define DIFF_DRIVE_ODOMETRY_INTEGRATOR_MACROS_SVH

// Same-cycle implication, disabled while rstn is low.
`define DDOI_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("odometry integrator check failed");

// Next-cycle implication, disabled while rstn is low.
`define DDOI_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("odometry integrator check failed");

`endif

// ===== rtl/core/ddoi_pkg.sv =====
// Shared constants, types and the arctangent table of the odometry integrator.
`timescale 1ns / 1ps
`default_nettype none

package ddoi_pkg;

    // CORDIC configuration.
    localparam int CORDIC_STEPS = 16;
    localparam int ANGLE_BITS   = 16;
    localparam int CSTEP_W      = $clog2(CORDIC_STEPS + 1);
    localparam int ANGLE_DROP   = 32 - ANGLE_BITS;
    localparam logic [31:0] ANGLE_MASK = ~((32'd1 << ANGLE_DROP) - 32'd1);
    localparam logic [32:0] ANGLE_HALF = 33'd1 << (ANGLE_DROP - 1);

    // Vector and angle widths of the rotator.
    localparam int CXY_W = 34;
    localparam int CZ_W  = 33;
    localparam int CS_W  = 19;
    localparam logic signed [CXY_W-1:0] CORDIC_GAIN = CXY_W'(652032874);

    // Serial multiplier: signed multiplicand, multiplier consumed one bit a cycle.
    localparam int MUL_A_W   = 57;
    localparam int MUL_B_W   = 32;
    localparam int MUL_P_W   = MUL_A_W + MUL_B_W + 2;
    localparam int MUL_CNT_W = $clog2(MUL_B_W + 1);

    // Serial divider for the encoder yaw rate.
    localparam int NUM_W     = 76;
    localparam int DEN_W     = 24;
    localparam int QUO_W     = 33;
    localparam int DIV_CNT_W = $clog2(NUM_W + 1);

    localparam logic [19:0] USEC_PER_SEC = 20'd1000000;

    typedef struct packed {
        logic start;
        logic b_signed;
    } mul_ctl_t;

    // Arctangent of 2^-i in 2^32 units per turn, rounded to ANGLE_BITS bits.
    function automatic logic [31:0] atan_entry(input logic [4:0] idx);
        logic [31:0] raw;
        logic [32:0] rnd;
        unique case (idx)
            5'd0:    raw = 32'd536870912;
            5'd1:    raw = 32'd316933406;
            5'd2:    raw = 32'd167458907;
            5'd3:    raw = 32'd85004756;
            5'd4:    raw = 32'd42667331;
            5'd5:    raw = 32'd21354465;
            5'd6:    raw = 32'd10679838;
            5'd7:    raw = 32'd5340245;
            5'd8:    raw = 32'd2670163;
            5'd9:    raw = 32'd1335087;
            5'd10:   raw = 32'd667544;
            5'd11:   raw = 32'd333772;
            5'd12:   raw = 32'd166886;
            5'd13:   raw = 32'd83443;
            5'd14:   raw = 32'd41722;
            5'd15:   raw = 32'd20861;
            5'd16:   raw = 32'd10430;
            5'd17:   raw = 32'd5215;
            5'd18:   raw = 32'd2608;
            5'd19:   raw = 32'd1304;
            5'd20:   raw = 32'd652;
            5'd21:   raw = 32'd326;
            5'd22:   raw = 32'd163;
            5'd23:   raw = 32'd81;
            default: raw = 32'd0;
        endcase
        rnd = {1'b0, raw} + ANGLE_HALF;
        return rnd[31:0] & ANGLE_MASK;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/ddoi_mul.sv =====
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module ddoi_mul
    import ddoi_pkg::*;
(
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire mul_ctl_t                  ctl,
    input  wire logic signed [MUL_A_W-1:0] a,
    input  wire logic [MUL_B_W-1:0]        b,
    output logic                           done,
    output logic signed [MUL_P_W-1:0]      prod
);

    logic signed [MUL_A_W-1:0] a_reg;
    logic signed [MUL_A_W+1:0] hi_reg;
    logic [MUL_B_W-1:0]        lo_reg;
    logic [MUL_CNT_W-1:0]      cnt_reg;
    logic                      busy_reg;
    logic                      sgn_reg;
    logic                      done_reg;

    logic                      last;
    logic signed [MUL_A_W+1:0] a_ext;
    logic signed [MUL_A_W+1:0] addend;
    logic signed [MUL_A_W+1:0] sum;

    assign last  = (cnt_reg == MUL_CNT_W'(MUL_B_W - 1));
    assign a_ext = (MUL_A_W + 2)'(a_reg);

    // A signed multiplier carries negative weight in its top bit.
    always_comb begin
        if (!lo_reg[0]) begin
            addend = '0;
        end else if (last && sgn_reg) begin
            addend = -a_ext;
        end else begin
            addend = a_ext;
        end
        sum = hi_reg + addend;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (ctl.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + MUL_CNT_W'(1);
                if (last) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.start) begin
            a_reg   <= a;
            sgn_reg <= ctl.b_signed;
            hi_reg  <= '0;
            lo_reg  <= b;
        end else if (busy_reg) begin
            hi_reg <= sum >>> 1;
            lo_reg <= {sum[0], lo_reg[MUL_B_W-1:1]};
        end
    end

    assign done = done_reg;
    assign prod = {hi_reg, lo_reg};

endmodule

`default_nettype wire

// ===== rtl/core/ddoi_div.sv =====
// Restoring bit-serial divider with quotient overflow flag.
`timescale 1ns / 1ps
`default_nettype none

module ddoi_div
    import ddoi_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              start,
    input  wire logic [NUM_W-1:0]  num,
    input  wire logic [DEN_W-1:0]  den,
    output logic                   done,
    output logic [QUO_W-1:0]       quo,
    output logic                   ovf
);

    logic [NUM_W-1:0]     num_reg;
    logic [DEN_W-1:0]     den_reg;
    logic [DEN_W-1:0]     rem_reg;
    logic [QUO_W-1:0]     quo_reg;
    logic                 ovf_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;

    logic [DEN_W:0]       trial;
    logic                 ge;
    logic [DEN_W:0]       diff;

    assign trial = {rem_reg, num_reg[NUM_W-1]};
    assign ge    = (trial >= {1'b0, den_reg});
    assign diff  = trial - {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + DIV_CNT_W'(1);
                if (cnt_reg == DIV_CNT_W'(NUM_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Quotient bits that fall off the top mark a result past the 33-bit range.
    always_ff @(posedge aclk) begin
        if (start) begin
            num_reg <= num;
            den_reg <= den;
            rem_reg <= '0;
            quo_reg <= '0;
            ovf_reg <= 1'b0;
        end else if (busy_reg) begin
            num_reg <= {num_reg[NUM_W-2:0], 1'b0};
            rem_reg <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            quo_reg <= {quo_reg[QUO_W-2:0], ge};
            ovf_reg <= ovf_reg | quo_reg[QUO_W-1];
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;
    assign ovf  = ovf_reg;

endmodule

`default_nettype wire

// ===== rtl/core/ddoi_cordic.sv =====
// Iterative rotation-mode CORDIC giving cosine and sine of the heading.
`timescale 1ns / 1ps
`default_nettype none

module ddoi_cordic
    import ddoi_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              start,
    input  wire logic [15:0]       heading,
    output logic signed [CS_W-1:0] cos_q,
    output logic signed [CS_W-1:0] sin_q
);

    logic signed [CXY_W-1:0] x_reg;
    logic signed [CXY_W-1:0] y_reg;
    logic signed [CZ_W-1:0]  z_reg;
    logic [CSTEP_W-1:0]      i_reg;
    logic                    busy_reg;

    logic [31:0]             ang;
    logic [31:0]             ang_q;
    logic signed [CXY_W-1:0] x_sh;
    logic signed [CXY_W-1:0] y_sh;
    logic signed [CZ_W-1:0]  t;
    logic signed [CXY_W-1:0] x_rnd;
    logic signed [CXY_W-1:0] y_rnd;

    assign ang   = {heading, 16'h0000} & ANGLE_MASK;
    assign ang_q = ang + 32'h4000_0000;
    assign x_sh  = x_reg >>> i_reg;
    assign y_sh  = y_reg >>> i_reg;
    assign t     = $signed(CZ_W'(atan_entry(5'(i_reg))));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            i_reg    <= '0;
        end else begin
            if (start) begin
                busy_reg <= 1'b1;
                i_reg    <= '0;
            end else if (busy_reg) begin
                if (i_reg == CSTEP_W'(CORDIC_STEPS - 1)) begin
                    busy_reg <= 1'b0;
                end else begin
                    i_reg <= i_reg + CSTEP_W'(1);
                end
            end
        end
    end

    // Angles in the left half plane start from the negated vector.
    always_ff @(posedge aclk) begin
        if (start) begin
            y_reg <= '0;
            if (ang_q[31]) begin
                x_reg <= -CORDIC_GAIN;
                z_reg <= CZ_W'($signed(ang - 32'h8000_0000));
            end else begin
                x_reg <= CORDIC_GAIN;
                z_reg <= CZ_W'($signed(ang));
            end
        end else if (busy_reg) begin
            if (!z_reg[CZ_W-1]) begin
                x_reg <= x_reg - y_sh;
                y_reg <= y_reg + x_sh;
                z_reg <= z_reg - t;
            end else begin
                x_reg <= x_reg + y_sh;
                y_reg <= y_reg - x_sh;
                z_reg <= z_reg + t;
            end
        end
    end

    assign x_rnd = (x_reg + CXY_W'(16384)) >>> 15;
    assign y_rnd = (y_reg + CXY_W'(16384)) >>> 15;
    assign cos_q = x_rnd[CS_W-1:0];
    assign sin_q = y_rnd[CS_W-1:0];

endmodule

`default_nettype wire

// ===== rtl/core/diff_drive_odometry_integrator.sv =====
// Top level of the differential-drive dead-reckoning odometry integrator.
`timescale 1ns / 1ps
`default_nettype none

// Each sensor frame request on the s_ channel (s_tuser low) updates heading and x/y position
// from wrapping encoder counts and produces one result on the m_ channel; a request with
// s_tuser high clears position and heading, sets the first-frame flag and produces no
// result. All arithmetic runs through one bit-serial multiplier, one bit-serial divider
// for the encoder yaw rate and a CORDIC that runs in the shadow of the distance product.
// A frame runs a chain of serial products, nine of them when the encoder yaw rate has to be
// divided out (not on the first frame or with zero elapsed time). One frame is worked on
// at a time, but a finished result waits in its own output register, so the next frame
// is taken while the previous result is still pending. Configuration registers sit on
// the APB port at byte address 4*i and must be written only while the block is idle.

module diff_drive_odometry_integrator
    import ddoi_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    // Input frame channel.
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // forward_count[31:0], yaw_count[63:32], left_speed[79:64], right_speed[95:80],
    // gyro_rate[111:96], elapsed_us[135:112]
    input  wire logic [135:0] s_tdata,
    // command[0]
    input  wire logic         s_tuser,
    // Result channel.
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // pos_x[31:0], pos_y[63:32], heading[79:64], forward_speed[111:80],
    // fused_yaw_rate[143:112]
    output logic [143:0]      m_tdata,
    // Configuration port.
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [4:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    // Register indexes on the configuration port.
    localparam logic [2:0] REG_MPC    = 3'd0;
    localparam logic [2:0] REG_APYC   = 3'd1;
    localparam logic [2:0] REG_SPC    = 3'd2;
    localparam logic [2:0] REG_GSCALE = 3'd3;
    localparam logic [2:0] REG_GBIAS  = 3'd4;
    localparam logic [2:0] REG_GTRUST = 3'd5;

    // Sequencer states; each arithmetic state runs one serial product, ST_EDIV the serial division.
    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_STEP   = 4'd1;
    localparam logic [3:0] ST_DIST   = 4'd2;
    localparam logic [3:0] ST_XMUL   = 4'd3;
    localparam logic [3:0] ST_YMUL   = 4'd4;
    localparam logic [3:0] ST_EMUL   = 4'd5;
    localparam logic [3:0] ST_EDIV   = 4'd6;
    localparam logic [3:0] ST_GMUL   = 4'd7;
    localparam logic [3:0] ST_GTRUST = 4'd8;
    localparam logic [3:0] ST_ETRUST = 4'd9;
    localparam logic [3:0] ST_SPD    = 4'd10;
    localparam logic [3:0] ST_DONE   = 4'd11;

    // Configuration registers.
    logic [31:0] mpc_reg;
    logic [23:0] apyc_reg;
    logic [23:0] spc_reg;
    logic [23:0] gscale_reg;
    logic [31:0] gbias_reg;
    logic [8:0]  gtrust_reg;

    // Odometry state.
    logic [31:0] last_fwd_reg;
    logic [31:0] last_yaw_reg;
    logic        first_reg;
    logic [15:0] heading_reg;
    logic [31:0] x_reg;
    logic [31:0] y_reg;

    // Per-frame working registers.
    logic [3:0]         state_reg;
    logic signed [31:0] dlin_reg;
    logic signed [31:0] dang_reg;
    logic signed [16:0] negg_reg;
    logic signed [16:0] lrsum_reg;
    logic [23:0]        dt_reg;
    logic               enc_zero_reg;
    logic signed [55:0] step_reg;
    logic signed [47:0] d_reg;
    logic signed [31:0] enc_reg;
    logic signed [41:0] gyro_reg;
    logic signed [51:0] fsum_reg;
    logic [31:0]        fused_reg;
    logic [31:0]        spd_reg;
    logic               mul_go_reg;
    logic               cor_go_reg;
    logic               div_go_reg;

    // Output register.
    logic               m_valid_reg;
    logic [143:0]       out_data_reg;

    // Unit connections.
    mul_ctl_t                  mul_ctl;
    logic signed [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0]        mul_b;
    logic                      mul_bs;
    logic                      mul_done;
    logic signed [MUL_P_W-1:0] mul_prod;
    logic signed [CS_W-1:0]    cos_q;
    logic signed [CS_W-1:0]    sin_q;
    logic                      div_done;
    logic [QUO_W-1:0]          div_quo;
    logic                      div_ovf;

    logic               cfg_wr;
    logic               in_take;
    logic               load_out;
    logic [55:0]        mag;
    logic [8:0]         trust;
    logic [8:0]         untrust;
    logic               enc_big;
    logic signed [31:0] enc_w;
    logic signed [51:0] ftotal;

    function automatic logic [31:0] sat32(input logic signed [43:0] v);
        if (v[43:31] == '0 || v[43:31] == '1) begin
            return v[31:0];
        end else if (v[43]) begin
            return 32'h8000_0000;
        end else begin
            return 32'h7FFF_FFFF;
        end
    endfunction

    // ------------------------------------------------------------------
    // Configuration port. Writes complete in the access phase; reads are
    // served combinationally, so pready is tied high.
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mpc_reg    <= '0;
            apyc_reg   <= '0;
            spc_reg    <= '0;
            gscale_reg <= '0;
            gbias_reg  <= '0;
            gtrust_reg <= 9'd128;
        end else if (cfg_wr) begin
            case (paddr[4:2])
                REG_MPC:    mpc_reg    <= pwdata;
                REG_APYC:   apyc_reg   <= pwdata[23:0];
                REG_SPC:    spc_reg    <= pwdata[23:0];
                REG_GSCALE: gscale_reg <= pwdata[23:0];
                REG_GBIAS:  gbias_reg  <= pwdata;
                REG_GTRUST: gtrust_reg <= pwdata[8:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            REG_MPC:    prdata = mpc_reg;
            REG_APYC:   prdata = {8'h00, apyc_reg};
            REG_SPC:    prdata = {8'h00, spc_reg};
            REG_GSCALE: prdata = {8'h00, gscale_reg};
            REG_GBIAS:  prdata = gbias_reg;
            REG_GTRUST: prdata = {23'h0, gtrust_reg};
            default:    prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Operand selection for the shared serial multiplier.
    // ------------------------------------------------------------------
    assign mag     = step_reg[55] ? 56'(-step_reg) : 56'(step_reg);
    assign trust   = (gtrust_reg > 9'd256) ? 9'd256 : gtrust_reg;
    assign untrust = 9'd256 - trust;

    always_comb begin
        mul_a  = '0;
        mul_b  = '0;
        mul_bs = 1'b0;
        case (state_reg)
            ST_STEP: begin
                mul_a = MUL_A_W'(dang_reg);
                mul_b = MUL_B_W'(apyc_reg);
            end
            ST_DIST: begin
                mul_a = MUL_A_W'(dlin_reg);
                mul_b = mpc_reg;
            end
            ST_XMUL: begin
                mul_a  = MUL_A_W'(d_reg);
                mul_b  = MUL_B_W'(cos_q);
                mul_bs = 1'b1;
            end
            ST_YMUL: begin
                mul_a  = MUL_A_W'(d_reg);
                mul_b  = MUL_B_W'(sin_q);
                mul_bs = 1'b1;
            end
            ST_EMUL: begin
                mul_a = $signed(MUL_A_W'(mag));
                mul_b = MUL_B_W'(USEC_PER_SEC);
            end
            ST_GMUL: begin
                mul_a = MUL_A_W'(negg_reg);
                mul_b = MUL_B_W'(gscale_reg);
            end
            ST_GTRUST: begin
                mul_a = MUL_A_W'(gyro_reg);
                mul_b = MUL_B_W'(trust);
            end
            ST_ETRUST: begin
                mul_a = MUL_A_W'(enc_reg);
                mul_b = MUL_B_W'(untrust);
            end
            ST_SPD: begin
                mul_a = MUL_A_W'(lrsum_reg);
                mul_b = MUL_B_W'(spc_reg);
            end
            default: ;
        endcase
    end

    assign mul_ctl.start    = mul_go_reg;
    assign mul_ctl.b_signed = mul_bs;

    ddoi_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (mul_ctl),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .prod    (mul_prod)
    );

    // The rotator starts with the distance product and finishes well before it.
    ddoi_cordic u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cor_go_reg),
        .heading (heading_reg),
        .cos_q   (cos_q),
        .sin_q   (sin_q)
    );

    // The divider takes the scaled step magnitude straight from the multiplier.
    ddoi_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_go_reg),
        .num     (mul_prod[NUM_W-1:0]),
        .den     (dt_reg),
        .done    (div_done),
        .quo     (div_quo),
        .ovf     (div_ovf)
    );

    // The encoder rate magnitude saturates at 2^33 before it is clamped to
    // the signed 32-bit range; both limits collapse into one test here.
    assign enc_big = div_ovf | div_quo[32] | div_quo[31];

    always_comb begin
        if (step_reg[55]) begin
            enc_w = enc_big ? 32'sh8000_0000 : $signed(32'd0 - div_quo[31:0]);
        end else begin
            enc_w = enc_big ? 32'sh7FFF_FFFF : $signed(div_quo[31:0]);
        end
    end

    assign ftotal = fsum_reg + $signed(mul_prod[51:0]);

    // ------------------------------------------------------------------
    // Frame sequencer.
    // ------------------------------------------------------------------
    assign s_tready = (state_reg == ST_IDLE);
    assign in_take  = s_tvalid && s_tready;
    assign load_out = (state_reg == ST_DONE) && (!m_valid_reg || m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            mul_go_reg   <= 1'b0;
            cor_go_reg   <= 1'b0;
            div_go_reg   <= 1'b0;
            last_fwd_reg <= '0;
            last_yaw_reg <= '0;
            first_reg    <= 1'b1;
            heading_reg  <= '0;
            x_reg        <= '0;
            y_reg        <= '0;
        end else begin
            mul_go_reg <= 1'b0;
            cor_go_reg <= 1'b0;
            div_go_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE: begin
                    if (in_take && s_tuser) begin
                        // Odometry reset: the last counts are kept.
                        x_reg       <= '0;
                        y_reg       <= '0;
                        heading_reg <= '0;
                        first_reg   <= 1'b1;
                    end else if (in_take) begin
                        last_fwd_reg <= s_tdata[31:0];
                        last_yaw_reg <= s_tdata[63:32];
                        first_reg    <= 1'b0;
                        mul_go_reg   <= 1'b1;
                        state_reg    <= ST_STEP;
                    end
                end
                ST_STEP: begin
                    if (mul_done) begin
                        heading_reg <= heading_reg + mul_prod[31:16];
                        cor_go_reg  <= 1'b1;
                        mul_go_reg  <= 1'b1;
                        state_reg   <= ST_DIST;
                    end
                end
                ST_DIST: begin
                    if (mul_done) begin
                        mul_go_reg <= 1'b1;
                        state_reg  <= ST_XMUL;
                    end
                end
                ST_XMUL: begin
                    if (mul_done) begin
                        x_reg      <= x_reg + mul_prod[46:15];
                        mul_go_reg <= 1'b1;
                        state_reg  <= ST_YMUL;
                    end
                end
                ST_YMUL: begin
                    if (mul_done) begin
                        y_reg      <= y_reg + mul_prod[46:15];
                        mul_go_reg <= 1'b1;
                        state_reg  <= enc_zero_reg ? ST_GMUL : ST_EMUL;
                    end
                end
                ST_EMUL: begin
                    if (mul_done) begin
                        div_go_reg <= 1'b1;
                        state_reg  <= ST_EDIV;
                    end
                end
                ST_EDIV: begin
                    if (div_done) begin
                        mul_go_reg <= 1'b1;
                        state_reg  <= ST_GMUL;
                    end
                end
                ST_GMUL: begin
                    if (mul_done) begin
                        mul_go_reg <= 1'b1;
                        state_reg  <= ST_GTRUST;
                    end
                end
                ST_GTRUST: begin
                    if (mul_done) begin
                        mul_go_reg <= 1'b1;
                        state_reg  <= ST_ETRUST;
                    end
                end
                ST_ETRUST: begin
                    if (mul_done) begin
                        mul_go_reg <= 1'b1;
                        state_reg  <= ST_SPD;
                    end
                end
                ST_SPD: begin
                    if (mul_done) begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (load_out) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Datapath registers of the current frame.
    always_ff @(posedge aclk) begin
        if (in_take && !s_tuser) begin
            // Count differences are zero on the first frame after reset.
            dlin_reg     <= first_reg ? 32'sd0 : $signed(s_tdata[31:0] - last_fwd_reg);
            dang_reg     <= first_reg ? 32'sd0 : $signed(s_tdata[63:32] - last_yaw_reg);
            lrsum_reg    <= 17'($signed(s_tdata[79:64])) + 17'($signed(s_tdata[95:80]));
            negg_reg     <= -17'($signed(s_tdata[111:96]));
            dt_reg       <= s_tdata[135:112];
            enc_zero_reg <= first_reg || (s_tdata[135:112] == 24'd0);
        end
        if (mul_done) begin
            unique case (state_reg)
                ST_STEP:   step_reg <= mul_prod[55:0];
                ST_DIST:   d_reg    <= mul_prod[63:16];
                ST_GMUL: begin
                    gyro_reg <= $signed({mul_prod[40], mul_prod[40:0]})
                              - $signed({{10{gbias_reg[31]}}, gbias_reg});
                end
                ST_GTRUST: fsum_reg  <= mul_prod[51:0];
                ST_ETRUST: fused_reg <= sat32(ftotal[51:8]);
                ST_SPD:    spd_reg   <= sat32($signed({{11{mul_prod[41]}}, mul_prod[41:9]}));
                default: ;
            endcase
        end
        if (state_reg == ST_YMUL && mul_done && enc_zero_reg) begin
            enc_reg <= '0;
        end else if (state_reg == ST_EDIV && div_done) begin
            enc_reg <= enc_w;
        end
    end

    // ------------------------------------------------------------------
    // Output register: holds a finished result until it is taken.
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            out_data_reg <= {fused_reg, spd_reg, heading_reg, y_reg, x_reg};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

`default_nettype wire

// ===== rtl/core/ddoi_checker.sv =====
// Port-level checker for the odometry integrator and its bind statement.
`timescale 1ns / 1ps
`default_nettype none

`include "diff_drive_odometry_integrator_macros.svh"

module ddoi_checker (
    input wire logic         aclk,
    input wire logic         aresetn,
    input wire logic         s_tvalid,
    input wire logic         s_tready,
    input wire logic         s_tuser,
    input wire logic         m_tvalid,
    input wire logic         m_tready,
    input wire logic [143:0] m_tdata
);

    // A stalled result keeps its value.
    `DDOI_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // Reset leaves no result pending.
    `DDOI_ASSERT_NEXT(a_reset_empty, aclk, 1'b1, !aresetn, !m_tvalid)

    // An odometry reset request completes at once and the block stays ready.
    `DDOI_ASSERT_NEXT(a_cmd_quick, aclk, aresetn, s_tvalid && s_tready && s_tuser, s_tready)

    // A sensor frame keeps the block busy for its arithmetic.
    `DDOI_ASSERT_NEXT(a_frame_busy, aclk, aresetn, s_tvalid && s_tready && !s_tuser, !s_tready)

endmodule

bind diff_drive_odometry_integrator ddoi_checker u_ddoi_checker (.*);

`default_nettype wire
